// ----- rtl/cbl_pkg.sv -----
// ----------------------------------------------------------------------------
// cbl_pkg
// shared types, codes and defaults of the convolution engine
// ----------------------------------------------------------------------------
package cbl_pkg;

    localparam int DEF_MAX_CHANNELS = 16;
    localparam int DEF_MAX_KERNELS  = 16;
    localparam int DEF_MAX_WINDOW   = 3;
    localparam int DEF_MAX_HEIGHT   = 64;
    localparam int DEF_MAX_WIDTH    = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int LEAK_SLOPE  = 6554;

    // item kinds
    localparam logic [1:0] KIND_FEATURE = 2'd0;
    localparam logic [1:0] KIND_WEIGHT  = 2'd1;
    localparam logic [1:0] KIND_SCALE   = 2'd2;
    localparam logic [1:0] KIND_QUERY   = 2'd3;

    // register indexes
    localparam logic [2:0] REG_CHANNELS = 3'd0;
    localparam logic [2:0] REG_KERNELS  = 3'd1;
    localparam logic [2:0] REG_WINDOW   = 3'd2;
    localparam logic [2:0] REG_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_WIDTH    = 3'd4;
    localparam logic [2:0] REG_LEAKY    = 3'd5;

    typedef struct packed {
        logic [4:0] channel_count;
        logic [4:0] kernel_count;
        logic [1:0] window_size;
        logic [6:0] map_height;
        logic [6:0] map_width;
        logic       leaky_enable;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         kind;
        logic               in_range;
        logic [15:0]        address;
        logic signed [15:0] data_word;
        logic signed [31:0] offset_word;
        logic [3:0]         out_channel;
        logic [5:0]         out_row;
        logic [5:0]         out_col;
    } t_cmd;

endpackage

// ----- rtl/cbl_front.sv -----
// ----------------------------------------------------------------------------
// cbl_front
// takes input transactions, classifies them and pushes commands to the queue
// ----------------------------------------------------------------------------
module cbl_front
    import cbl_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_KERNELS  = DEF_MAX_KERNELS,
    parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH
) (
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam longint FEAT_DEPTH = longint'(MAX_CHANNELS) * MAX_HEIGHT * MAX_WIDTH;
    localparam longint WGT_DEPTH  =
        longint'(MAX_KERNELS) * MAX_CHANNELS * MAX_WINDOW * MAX_WINDOW;

    logic [15:0] addr;

    assign addr          = s_axis_tdata[15:0];
    assign s_axis_tready = !i_full;
    assign o_push        = s_axis_tvalid && !i_full;

    always_comb begin
        o_cmd             = '0;
        o_cmd.kind        = s_axis_tuser;
        o_cmd.address     = addr;
        o_cmd.data_word   = s_axis_tdata[31:16];
        o_cmd.offset_word = s_axis_tdata[63:32];
        o_cmd.out_channel = s_axis_tdata[67:64];
        o_cmd.out_row     = s_axis_tdata[73:68];
        o_cmd.out_col     = s_axis_tdata[79:74];
        // loads beyond the store depth are dropped by the engine
        unique case (s_axis_tuser)
            KIND_FEATURE: o_cmd.in_range = longint'(addr) < FEAT_DEPTH;
            KIND_WEIGHT:  o_cmd.in_range = longint'(addr) < WGT_DEPTH;
            KIND_SCALE:   o_cmd.in_range = int'(addr) < MAX_KERNELS;
            KIND_QUERY:   o_cmd.in_range = 1'b1;
            default:      o_cmd.in_range = 1'b0;
        endcase
    end

endmodule

// ----- rtl/cbl_queue.sv -----
// ----------------------------------------------------------------------------
// cbl_queue
// short command queue between front and engine
// ----------------------------------------------------------------------------
module cbl_queue
    import cbl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = r_cnt == (PW+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule

// ----- rtl/cbl_engine.sv -----
// ----------------------------------------------------------------------------
// cbl_engine
// stores, multiply-accumulate walk, scale/offset, activation, output register
// ----------------------------------------------------------------------------
module cbl_engine
    import cbl_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_KERNELS  = DEF_MAX_KERNELS,
    parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_value,
    output logic        o_saturated,
    output logic        o_bad
);

    localparam int FEAT_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int WGT_DEPTH  = MAX_KERNELS * MAX_CHANNELS * MAX_WINDOW * MAX_WINDOW;
    localparam int FAW  = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
    localparam int WAW  = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
    localparam int KAW  = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;
    localparam int NCW  = $clog2(MAX_CHANNELS + 1);
    localparam int NKW  = $clog2(MAX_KERNELS + 1);
    localparam int NHW  = $clog2(MAX_HEIGHT + 1);
    localparam int NWW  = $clog2(MAX_WIDTH + 1);
    localparam int KW   = $clog2(MAX_WINDOW + 1);
    localparam int ACCW = 32 + $clog2(MAX_CHANNELS * MAX_WINDOW * MAX_WINDOW + 1);
    localparam int M1W  = ACCW + 16;
    localparam int YW   = ACCW + 6;
    localparam int M2W  = YW + 14;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_P1    = 3'd3;
    localparam logic [2:0] S_P2    = 3'd4;
    localparam logic [2:0] S_P3    = 3'd5;
    localparam logic [2:0] S_P4    = 3'd6;

    logic [15:0] mem_feat  [FEAT_DEPTH];
    logic [15:0] mem_wgt   [WGT_DEPTH];
    logic [15:0] mem_scale [MAX_KERNELS];
    logic [31:0] mem_offs  [MAX_KERNELS];

    logic [2:0]  r_state, n_state;
    logic [NCW-1:0] r_c, n_c;
    logic [KW-1:0]  r_ky, n_ky, r_kx, n_kx;
    logic [3:0]  r_k;
    logic [5:0]  r_row, r_col;
    logic        r_bad;
    logic        r_p1, r_p2, r_tv1, r_tv2;
    logic signed [15:0] r_fd, r_wd, r_scale;
    logic signed [31:0] r_offs, r_prod;
    logic signed [ACCW-1:0] r_acc;
    logic signed [M1W-1:0]  r_m1;
    logic signed [YW-1:0]   r_y;
    logic signed [M2W-1:0]  r_m2;
    logic        r_out_valid;
    logic [15:0] r_value;
    logic        r_sat, r_out_bad;

    logic [NCW-1:0] nc;
    logic [NKW-1:0] nk;
    logic [NHW-1:0] h;
    logic [NWW-1:0] w;
    logic [KW-1:0]  win, rad;
    int             sy, sx;
    logic           tap_valid, issue, last_tap, start_query, q_bad;
    logic [FAW-1:0] fi;
    logic [WAW-1:0] wi;
    logic [KAW-1:0] kidx;
    logic signed [M1W-1:0] m1_rnd;
    logic signed [YW-1:0]  y_next;
    logic signed [M2W:0]   z_leak, z_lin, z;
    logic signed [15:0]    z_sat;
    logic                  z_clip, out_free;

    // clamp configuration to what the stores hold
    assign nc  = (int'(i_cfg.channel_count) > MAX_CHANNELS) ? NCW'(MAX_CHANNELS)
                                                             : NCW'(i_cfg.channel_count);
    assign nk  = (int'(i_cfg.kernel_count) > MAX_KERNELS) ? NKW'(MAX_KERNELS)
                                                          : NKW'(i_cfg.kernel_count);
    assign h   = (int'(i_cfg.map_height) > MAX_HEIGHT) ? NHW'(MAX_HEIGHT)
                                                       : NHW'(i_cfg.map_height);
    assign w   = (int'(i_cfg.map_width) > MAX_WIDTH) ? NWW'(MAX_WIDTH)
                                                     : NWW'(i_cfg.map_width);
    assign win = (int'(i_cfg.window_size) > MAX_WINDOW) ? KW'(MAX_WINDOW)
                                                        : KW'(i_cfg.window_size);
    assign rad = win >> 1;

    assign kidx = KAW'(r_k);
    assign o_pop = (r_state == S_IDLE) && i_q_valid;
    assign start_query = o_pop && (i_q_cmd.kind == KIND_QUERY);
    assign q_bad = (int'(i_q_cmd.out_channel) >= int'(nk)) ||
                   (int'(i_q_cmd.out_row) >= int'(h)) ||
                   (int'(i_q_cmd.out_col) >= int'(w));

    // tap address generation
    always_comb begin
        sy = int'(r_row) + int'(r_ky) - int'(rad);
        sx = int'(r_col) + int'(r_kx) - int'(rad);
        issue = r_state == S_RUN;
        tap_valid = issue && (sy >= 0) && (sx >= 0) && (sy < int'(h)) && (sx < int'(w));
        fi = '0;
        if (tap_valid) begin
            fi = FAW'((int'(r_c) * MAX_HEIGHT + sy) * MAX_WIDTH + sx);
        end
        wi = WAW'(((int'(r_k) * MAX_CHANNELS + int'(r_c)) * MAX_WINDOW + int'(r_ky))
                  * MAX_WINDOW + int'(r_kx));
        last_tap = (r_kx == win - 1'b1) && (r_ky == win - 1'b1) &&
                   (r_c == nc - 1'b1);
    end

    // post-processing arithmetic
    always_comb begin
        m1_rnd = r_m1 + M1W'(2048);
        y_next = YW'(m1_rnd >>> 12) + YW'(r_offs);
        z_leak = (M2W+1)'((r_m2 + M2W'(1 << 23)) >>> 24);
        z_lin  = (M2W+1)'((r_y + YW'(128)) >>> 8);
        z      = (i_cfg.leaky_enable && r_y < 0) ? z_leak : z_lin;
        z_clip = 1'b0;
        z_sat  = z[15:0];
        if (z > (M2W+1)'(32767)) begin
            z_sat  = 16'sh7fff;
            z_clip = 1'b1;
        end else if (z < -(M2W+1)'(32768)) begin
            z_sat  = 16'sh8000;
            z_clip = 1'b1;
        end
        out_free = !r_out_valid || i_ready;
    end

    always_comb begin
        n_state = r_state;
        n_c  = r_c;
        n_ky = r_ky;
        n_kx = r_kx;
        unique case (r_state)
            S_IDLE: begin
                if (start_query) begin
                    n_c = '0; n_ky = '0; n_kx = '0;
                    if (q_bad) begin
                        n_state = S_P4;
                    end else if (nc == '0 || win == '0) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (last_tap) begin
                    n_state = S_DRAIN;
                end else if (r_kx == win - 1'b1) begin
                    n_kx = '0;
                    if (r_ky == win - 1'b1) begin
                        n_ky = '0;
                        n_c  = r_c + 1'b1;
                    end else begin
                        n_ky = r_ky + 1'b1;
                    end
                end else begin
                    n_kx = r_kx + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!r_p1 && !r_p2) begin
                    n_state = S_P1;
                end
            end
            S_P1: n_state = S_P2;
            S_P2: n_state = S_P3;
            S_P3: n_state = S_P4;
            S_P4: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_cmd.in_range) begin
            unique case (i_q_cmd.kind)
                KIND_FEATURE: mem_feat[FAW'(i_q_cmd.address)] <= i_q_cmd.data_word;
                KIND_WEIGHT:  mem_wgt[WAW'(i_q_cmd.address)]  <= i_q_cmd.data_word;
                KIND_SCALE: begin
                    mem_scale[KAW'(i_q_cmd.address)] <= i_q_cmd.data_word;
                    mem_offs[KAW'(i_q_cmd.address)]  <= i_q_cmd.offset_word;
                end
                KIND_QUERY: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_fd    <= mem_feat[fi];
        r_wd    <= mem_wgt[wi];
        r_scale <= mem_scale[kidx];
        r_offs  <= mem_offs[kidx];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_c  <= n_c;
        r_ky <= n_ky;
        r_kx <= n_kx;
        r_prod <= r_fd * r_wd;
        r_m1 <= r_acc * r_scale;
        r_y  <= y_next;
        r_m2 <= r_y * M2W'(LEAK_SLOPE);
        if (start_query) begin
            r_k   <= i_q_cmd.out_channel;
            r_row <= i_q_cmd.out_row;
            r_col <= i_q_cmd.out_col;
            r_bad <= q_bad;
            r_acc <= '0;
        end else if (r_tv2) begin
            r_acc <= r_acc + ACCW'(r_prod);
        end
        if (r_state == S_P4 && out_free) begin
            r_value   <= r_bad ? 16'd0 : z_sat;
            r_sat     <= !r_bad && z_clip;
            r_out_bad <= r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_tv1       <= 1'b0;
            r_tv2       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p1    <= issue;
            r_p2    <= r_p1;
            r_tv1   <= tap_valid;
            r_tv2   <= r_tv1;
            if (r_state == S_P4 && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value     = r_value;
    assign o_saturated = r_sat;
    assign o_bad       = r_out_bad;

endmodule

// ----- rtl/conv2d_bn_leaky.sv -----
// ----------------------------------------------------------------------------
// conv2d_bn_leaky
// same-padded 2d convolution point engine with scale/offset and leaky output
// ----------------------------------------------------------------------------
// input stream: tuser holds the item kind (feature, weight, scale/offset load
//   or query); tdata carries address, data, offset and query coordinates
// output stream: one transaction per query, result in Q8.8 with the
//   saturated and bad request flags in tuser; loads produce nothing
// apb port: six configuration registers at byte address 4*index, to be written
//   only while the block is idle, unchecked by the block; pready is tied high
// a load is written to its store when the idle engine takes it from the queue;
//   a query, once taken from the queue, walks channels*window*window taps, one
//   multiply-accumulate per cycle through a single multiplier, then drains the
//   product pipeline, applies scale and offset and then the activation with
//   saturation, and is offered from the output register
// a query with coordinates out of range skips the walk to the final stage
// the engine works on one item at a time, taking the next item only when the
//   last query has reached the output register; a four-entry command queue
//   lets the input side keep accepting while the engine is busy
// reset clears the control state and the registers to their defaults; the
//   stores hold nothing defined until loaded
// a stalled receiver holds the result in the output register; the engine
//   then waits at the final stage and the queue fills up behind it
// ----------------------------------------------------------------------------
module conv2d_bn_leaky
    import cbl_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_KERNELS  = DEF_MAX_KERNELS,
    parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address, data_word, offset_word, out_channel, out_row, out_col
    input  logic [79:0] s_axis_tdata,
    // kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_value
    output logic [15:0] m_axis_tdata,
    // saturated, bad_request
    output logic [1:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg r_cfg;
    t_cmd front_cmd, q_cmd;
    logic push, q_full, q_valid, pop;
    logic cfg_wr;
    logic sat, bad;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count <= 5'd1;
            r_cfg.kernel_count  <= 5'd1;
            r_cfg.window_size   <= 2'd3;
            r_cfg.map_height    <= 7'd64;
            r_cfg.map_width     <= 7'd64;
            r_cfg.leaky_enable  <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_CHANNELS: r_cfg.channel_count <= pwdata[4:0];
                REG_KERNELS:  r_cfg.kernel_count  <= pwdata[4:0];
                REG_WINDOW:   r_cfg.window_size   <= pwdata[1:0];
                REG_HEIGHT:   r_cfg.map_height    <= pwdata[6:0];
                REG_WIDTH:    r_cfg.map_width     <= pwdata[6:0];
                REG_LEAKY:    r_cfg.leaky_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_CHANNELS: prdata = 32'(r_cfg.channel_count);
            REG_KERNELS:  prdata = 32'(r_cfg.kernel_count);
            REG_WINDOW:   prdata = 32'(r_cfg.window_size);
            REG_HEIGHT:   prdata = 32'(r_cfg.map_height);
            REG_WIDTH:    prdata = 32'(r_cfg.map_width);
            REG_LEAKY:    prdata = 32'(r_cfg.leaky_enable);
            default:      prdata = '0;
        endcase
    end

    // front: classify input transactions
    cbl_front #(
        .MAX_CHANNELS(MAX_CHANNELS), .MAX_KERNELS(MAX_KERNELS),
        .MAX_WINDOW(MAX_WINDOW), .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .i_full       (q_full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    // decoupling queue
    cbl_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (front_cmd),
        .o_full (q_full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_cmd  (q_cmd)
    );

    // back: stores and compute
    cbl_engine #(
        .MAX_CHANNELS(MAX_CHANNELS), .MAX_KERNELS(MAX_KERNELS),
        .MAX_WINDOW(MAX_WINDOW), .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_value    (m_axis_tdata),
        .o_saturated(sat),
        .o_bad      (bad)
    );

    assign m_axis_tuser = {bad, sat};

endmodule

// ----- rtl/cbl_checker.sv -----
// ----------------------------------------------------------------------------
// cbl_checker
// port-level checks of the convolution engine
// ----------------------------------------------------------------------------
module cbl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        pready
);

    // a held result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // bad request carries a zero value and no clip
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 16'd0 && !m_axis_tuser[0])
        else $error("bad request with payload");

    // clipped results sit at a rail
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
        m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000)
        else $error("saturated value off the rails");

    // nothing offered right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind conv2d_bn_leaky cbl_checker u_cbl_checker (.*);
